// File: rtl/obbot_pkg.sv
package obbot_pkg;

  localparam int unsigned NumSepAxes = 15;
  localparam int unsigned NumStages  = 9;

  localparam int unsigned BiasWidth  = 8;
  localparam int unsigned ApbAw      = 3;
  localparam int unsigned ApbDw      = 32;

  localparam logic [ApbAw-1:0]     RegAbsRotBiasAddr = 3'd0;
  localparam logic [BiasWidth-1:0] AbsRotBiasRst     = 8'd1;

  typedef logic [BiasWidth-1:0] bias_t;

endpackage

// File: rtl/obb_obb_overlap_test.sv
// Channel   Direction  Handshake                   Payload
// -------   ---------  --------------------------  ----------------------------------
// request   in         start_i, busy_o             a_/b_ center, half, axis0..2
// result    out        result_valid_o              overlap_o
// config    in/out     psel/penable/pwrite/pready  paddr, pwdata, prdata
//
// result_valid_o is the last of the stage valid bits; it is high while overlap_o holds
// the result of the box pair it marks.
// Throughput: one box pair per cycle; the nine-stage datapath is fully pipelined.
// busy_o stays low: there is no backpressure since the result side cannot stall.
// Reset clears the stage valid bits and sets abs_rotation_bias to 1.
module obb_obb_overlap_test #(
  parameter int unsigned COORD_WIDTH = 20,
  parameter int unsigned AXIS_WIDTH  = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  output logic                              busy_o,
  input  logic [3*COORD_WIDTH-1:0]          a_center_i,
  input  logic [3*COORD_WIDTH-1:0]          a_half_i,
  input  logic [3*AXIS_WIDTH-1:0]           a_axis0_i,
  input  logic [3*AXIS_WIDTH-1:0]           a_axis1_i,
  input  logic [3*AXIS_WIDTH-1:0]           a_axis2_i,
  input  logic [3*COORD_WIDTH-1:0]          b_center_i,
  input  logic [3*COORD_WIDTH-1:0]          b_half_i,
  input  logic [3*AXIS_WIDTH-1:0]           b_axis0_i,
  input  logic [3*AXIS_WIDTH-1:0]           b_axis1_i,
  input  logic [3*AXIS_WIDTH-1:0]           b_axis2_i,
  output logic                              result_valid_o,
  output logic                              overlap_o,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [obbot_pkg::ApbAw-1:0]       paddr,
  input  logic [obbot_pkg::ApbDw-1:0]       pwdata,
  output logic [obbot_pkg::ApbDw-1:0]       prdata,
  output logic                              pready
);
  import obbot_pkg::*;

  localparam int unsigned C   = COORD_WIDTH;
  localparam int unsigned A   = AXIS_WIDTH;
  localparam int unsigned F   = AXIS_WIDTH - 2;
  localparam int unsigned DW  = C + 1;          // center difference
  localparam int unsigned DAW = DW + A;         // d * axis
  localparam int unsigned TW  = DAW + 2;        // projected offset t
  localparam int unsigned PRW = 2 * A;          // axis * axis
  localparam int unsigned RW  = PRW + 2;        // rotation term R
  localparam int unsigned ARW = RW - 1;         // |R| + bias
  localparam int unsigned HW  = C + ARW;        // half * AR
  localparam int unsigned TL  = TW / 2;         // low part of t, unsigned
  localparam int unsigned TH  = TW - TL;        // high part of t, signed
  localparam int unsigned PHW = TH + RW;
  localparam int unsigned PLW = TL + 1 + RW;
  localparam int unsigned PW  = TW + RW;        // t * R
  localparam int unsigned WW  = PW + 3;         // compare width

  // ---------------- configuration ----------------
  bias_t bias_q;
  logic  cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == RegAbsRotBiasAddr[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bias_q <= AbsRotBiasRst;
    end else if (cfg_wr) begin
      bias_q <= pwdata[BiasWidth-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == RegAbsRotBiasAddr[2]) begin
      prdata = ApbDw'(bias_q);
    end
  end

  // ---------------- stage valid bits ----------------
  logic                 accept;
  logic [NumStages-1:0] vld_q;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[NumStages-2:0], accept};
    end
  end

  // ---------------- stage 1: unpack, center offset ----------------
  logic [3*A-1:0] a_ax_w [3];
  logic [3*A-1:0] b_ax_w [3];

  assign a_ax_w[0] = a_axis0_i;
  assign a_ax_w[1] = a_axis1_i;
  assign a_ax_w[2] = a_axis2_i;
  assign b_ax_w[0] = b_axis0_i;
  assign b_ax_w[1] = b_axis1_i;
  assign b_ax_w[2] = b_axis2_i;

  logic signed [DW-1:0] d_q  [3];
  logic signed [A-1:0]  ax_q [3][3];
  logic signed [A-1:0]  bx_q [3][3];
  logic [6*C-1:0]       half_q [6];   // {b_half, a_half} per stage

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      d_q[k] <= DW'($signed(b_center_i[k*C +: C])) - DW'($signed(a_center_i[k*C +: C]));
      for (int i = 0; i < 3; i++) begin
        ax_q[i][k] <= $signed(a_ax_w[i][k*A +: A]);
        bx_q[i][k] <= $signed(b_ax_w[i][k*A +: A]);
      end
    end
    half_q[0] <= {b_half_i, a_half_i};
    for (int s = 1; s < 6; s++) begin
      half_q[s] <= half_q[s-1];
    end
  end

  // ---------------- stage 2: dot product terms ----------------
  logic signed [DAW-1:0] dax_q  [3][3];
  logic signed [PRW-1:0] axbx_q [3][3][3];

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      for (int k = 0; k < 3; k++) begin
        dax_q[i][k] <= d_q[k] * ax_q[i][k];
        for (int j = 0; j < 3; j++) begin
          axbx_q[i][j][k] <= ax_q[i][k] * bx_q[j][k];
        end
      end
    end
  end

  // ---------------- stage 3: t and R ----------------
  logic signed [TW-1:0] t_q [3];
  logic signed [RW-1:0] r_q [3][3];

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      t_q[i] <= TW'(dax_q[i][0]) + TW'(dax_q[i][1]) + TW'(dax_q[i][2]);
      for (int j = 0; j < 3; j++) begin
        r_q[i][j] <= RW'(axbx_q[i][j][0]) + RW'(axbx_q[i][j][1]) + RW'(axbx_q[i][j][2]);
      end
    end
  end

  // ---------------- stage 4: |R|+bias, split t ----------------
  logic [ARW-1:0]       ar_q   [3][3];
  logic signed [RW-1:0] r4_q   [3][3];
  logic signed [TH-1:0] th_q   [3];
  logic [TL-1:0]        tl_q   [3];

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      th_q[i] <= t_q[i][TW-1:TL];
      tl_q[i] <= t_q[i][TL-1:0];
      for (int j = 0; j < 3; j++) begin
        r4_q[i][j] <= r_q[i][j];
        ar_q[i][j] <= ARW'(r_q[i][j][RW-1] ? -r_q[i][j] : r_q[i][j]) + ARW'(bias_q);
      end
    end
  end

  logic [TW-1:0] abst4_q [3];
  logic [TW-1:0] abst5_q [3];

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      abst4_q[i] <= t_q[i][TW-1] ? TW'(-t_q[i]) : TW'(t_q[i]);
      abst5_q[i] <= abst4_q[i];
    end
  end

  // ---------------- stage 5: partial products ----------------
  logic [HW-1:0]         hap_q [3][3][3];   // ha[m] * AR[n][j]
  logic [HW-1:0]         hbp_q [3][3][3];   // hb[m] * AR[i][j]
  logic signed [PHW-1:0] ph_q  [3][3][3];   // t[k] high * R[m][j]
  logic signed [PLW-1:0] pl_q  [3][3][3];   // t[k] low  * R[m][j]

  always_ff @(posedge clk_i) begin
    for (int m = 0; m < 3; m++) begin
      for (int n = 0; n < 3; n++) begin
        for (int j = 0; j < 3; j++) begin
          hap_q[m][n][j] <= HW'(half_q[3][m*C +: C]) * HW'(ar_q[n][j]);
          hbp_q[m][n][j] <= HW'(half_q[3][3*C + m*C +: C]) * HW'(ar_q[n][j]);
          ph_q[m][n][j]  <= th_q[m] * r4_q[n][j];
          pl_q[m][n][j]  <= $signed({1'b0, tl_q[m]}) * r4_q[n][j];
        end
      end
    end
  end

  // ---------------- stage 6: full products, radius sums ----------------
  logic signed [PW-1:0] p_q     [3][3][3];
  logic [WW-1:0]        rab_q   [3];
  logic [WW-1:0]        rx_q    [3][3];
  logic [WW-1:0]        lhsa_q  [3];
  logic [WW-1:0]        rhsa_q  [3];

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      for (int m = 0; m < 3; m++) begin
        for (int j = 0; j < 3; j++) begin
          p_q[k][m][j] <= (PW'(ph_q[k][m][j]) <<< TL) + PW'(pl_q[k][m][j]);
        end
      end
    end
    for (int i = 0; i < 3; i++) begin
      lhsa_q[i] <= WW'(abst5_q[i]) << F;
      rhsa_q[i] <= (WW'(half_q[4][i*C +: C]) << (2*F)) + WW'(hbp_q[0][i][0])
                 + WW'(hbp_q[1][i][1]) + WW'(hbp_q[2][i][2]);
    end
    for (int j = 0; j < 3; j++) begin
      rab_q[j] <= WW'(hap_q[0][0][j]) + WW'(hap_q[1][1][j]) + WW'(hap_q[2][2][j]);
    end
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        rx_q[i][j] <= WW'(hap_q[(i+1)%3][(i+2)%3][j]) + WW'(hap_q[(i+2)%3][(i+1)%3][j])
                    + WW'(hbp_q[(j+1)%3][i][(j+2)%3]) + WW'(hbp_q[(j+2)%3][i][(j+1)%3]);
      end
    end
  end

  // ---------------- stage 7: projections per axis ----------------
  logic signed [WW-1:0] lhs_q [NumSepAxes];
  logic [WW-1:0]        rhs_q [NumSepAxes];

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      lhs_q[i] <= $signed(lhsa_q[i]);
      rhs_q[i] <= rhsa_q[i];
    end
    for (int j = 0; j < 3; j++) begin
      lhs_q[3+j] <= WW'(p_q[0][0][j]) + WW'(p_q[1][1][j]) + WW'(p_q[2][2][j]);
      rhs_q[3+j] <= (rab_q[j] << F) + (WW'(half_q[5][3*C + j*C +: C]) << (3*F));
    end
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        lhs_q[6+3*i+j] <= WW'(p_q[(i+2)%3][(i+1)%3][j]) - WW'(p_q[(i+1)%3][(i+2)%3][j]);
        rhs_q[6+3*i+j] <= rx_q[i][j] << F;
      end
    end
  end

  // ---------------- stage 8: separation test ----------------
  logic [NumSepAxes-1:0] sep_q;

  always_ff @(posedge clk_i) begin
    for (int x = 0; x < NumSepAxes; x++) begin
      sep_q[x] <= (lhs_q[x][WW-1] ? WW'(-lhs_q[x]) : WW'(lhs_q[x])) > rhs_q[x];
    end
  end

  // ---------------- stage 9: result ----------------
  logic overlap_q;

  always_ff @(posedge clk_i) begin
    overlap_q <= ~|sep_q;
  end

  assign overlap_o      = overlap_q;
  assign result_valid_o = vld_q[NumStages-1];

`ifndef SYNTHESIS
  a_lat_fwd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##9 result_valid_o)
    else $error("result strobe missing after transaction");

  a_lat_bwd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(accept, 9))
    else $error("result strobe without transaction");

  a_bias_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cfg_wr |=> $stable(bias_q))
    else $error("bias changed without a config write");

  a_bias_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_wr |=> bias_q == $past(pwdata[BiasWidth-1:0]))
    else $error("bias write lost");
`endif

endmodule
